>>> rtl/wspc_pkg.sv
// ----------------------------------------------------------------------------
// wspc_pkg
// Shared widths, codes and reset values of the two-wheel speed regulator.
// ----------------------------------------------------------------------------
package wspc_pkg;

  // Fixed point and datapath widths.
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned NUM_W     = 40;
  localparam int unsigned DEN_W     = 16;
  localparam int unsigned GAIN_W    = 10;
  localparam int unsigned OPND_W    = 18;
  localparam int unsigned ACC_W     = 30;

  // Request codes carried in the input tuser.
  localparam logic [1:0] REQ_CAPTURE  = 2'd0;
  localparam logic [1:0] REQ_OVERFLOW = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [2:0] REG_SPEED_NUM    = 3'd2;
  localparam logic [2:0] REG_MAX_DUTY     = 3'd3;
  localparam logic [2:0] REG_MIN_TARGET   = 3'd4;
  localparam logic [2:0] REG_EN_TIMEOUT   = 3'd5;
  localparam logic [2:0] REG_SAFETY_LEVEL = 3'd6;
  localparam logic [2:0] REG_SAFETY_LIMIT = 3'd7;

  // Constants of the control law.
  localparam logic [15:0]        PERIOD_STOPPED     = 16'hFFFF;
  localparam logic [15:0]        SPEED_MAX          = 16'd32767;
  localparam logic signed [18:0] INTEG_LIMIT        = 19'sd40960;
  localparam int unsigned        MIN_PERIOD_DEFAULT = 200;

  // Reset values of the configuration registers.
  localparam logic [9:0]  PROP_GAIN_RST    = 10'd150;
  localparam logic [9:0]  INTEG_GAIN_RST   = 10'd220;
  localparam logic [39:0] SPEED_NUM_RST    = 40'd0;
  localparam logic [15:0] MAX_DUTY_RST     = 16'd999;
  localparam logic [14:0] MIN_TARGET_RST   = 15'd20;
  localparam logic [7:0]  EN_TIMEOUT_RST   = 8'd50;
  localparam logic [15:0] SAFETY_LEVEL_RST = 16'd600;
  localparam logic [7:0]  SAFETY_LIMIT_RST = 8'd50;

endpackage

>>> rtl/wspc_div.sv
// ----------------------------------------------------------------------------
// wspc_div
// Restoring divider, one quotient bit per cycle, for speed = numerator/period.
// ----------------------------------------------------------------------------
module wspc_div
  import wspc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // Trial subtraction of one step.
  assign shifted = {rem_q, quot_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  // Control: counts the steps and flags the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      den_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quot_q <= {quot_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/wspc_mac.sv
// ----------------------------------------------------------------------------
// wspc_mac
// Shared multiply-accumulate unit for the two PI products.
// ----------------------------------------------------------------------------
module wspc_mac
  import wspc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    load_i,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic signed [OPND_W-1:0] opnd_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] prod;

  // Unsigned gain times signed operand, both widened to the sum width first.
  assign prod = ACC_W'($signed({1'b0, gain_i})) * ACC_W'(opnd_i);

  // Load starts a new sum; otherwise the product is added on.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= load_i ? prod : acc_q + prod;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/wheel_speed_pi_controller.sv
// Timing: capture and overflow beats update state in the accept cycle.
// A control tick steps through CALC, MUL_P, MUL_I, CLAMP and FIN, with DIV ahead
// of CALC when the 40-step serial divider recomputes the speed; FIN waits on a stall.
// Throughput: no new beat while a tick is in progress; capture beats every cycle while idle.
// Reset clears the wheel state, sets the enable countdowns to their default and loads the register defaults at once.
// ----------------------------------------------------------------------------
// wheel_speed_pi_controller
// Two-wheel PI speed regulator with a clamped integrator, enable timeout and
// a high-duty safety counter, sequenced over a serial divider and one MAC.
// ----------------------------------------------------------------------------
module wheel_speed_pi_controller
  import wspc_pkg::*;
#(
  parameter int unsigned MinPeriod = MIN_PERIOD_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: encoder_count[15:0], capture_period[31:16], target_speed[47:32],
  // emergency_stop[48], zero pad[55:49].
  input  logic [55:0] s_axis_tdata,
  // tuser: req_type[1:0], wheel[2].
  input  logic [2:0]  s_axis_tuser,
  // Result beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: drive_duty[15:0], reverse[16], safety_flag[17],
  // measured_speed[33:18], zero pad[39:34].
  output logic [39:0] m_axis_tdata,
  // tuser: out_wheel[0].
  output logic [0:0]  m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_MUL_P,
    ST_MUL_I,
    ST_CLAMP,
    ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [9:0]  prop_gain_q, integ_gain_q;
  logic [39:0] speed_num_q;
  logic [15:0] max_duty_q, safety_level_q;
  logic [14:0] min_target_q;
  logic [7:0]  en_timeout_q, safety_limit_q;

  // Per-wheel state.
  logic [15:0]        prev_enc_q   [2];
  logic               backward_q   [2];
  logic [15:0]        period_q     [2];
  logic [15:0]        speed_mag_q  [2];
  logic signed [17:0] integ_q      [2];
  logic [7:0]         countdown_q  [2];
  logic [8:0]         hd_count_q   [2];
  logic               safety_q;

  // Work registers of the tick in progress.
  logic               wheel_q;
  logic signed [15:0] target_q;
  logic               estop_q;
  logic signed [17:0] err_q;
  logic signed [17:0] integ_new_q;
  logic signed [16:0] speed_q;
  logic signed [ACC_W-1:0] duty_q;

  // Output register.
  logic        m_valid_q;
  logic        out_wheel_q;
  logic [15:0] out_duty_q;
  logic        out_rev_q;
  logic        out_safety_q;
  logic [15:0] out_speed_q;

  // Input fields.
  logic [1:0]  in_req;
  logic        in_wheel;
  logic [15:0] in_enc, in_per;
  logic signed [15:0] in_target;
  logic        in_estop;
  logic        in_accept;

  assign in_req    = s_axis_tuser[1:0];
  assign in_wheel  = s_axis_tuser[2];
  assign in_enc    = s_axis_tdata[15:0];
  assign in_per    = s_axis_tdata[31:16];
  assign in_target = $signed(s_axis_tdata[47:32]);
  assign in_estop  = s_axis_tdata[48];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Direction from encoder movement with half-range wrap detection.
  logic [15:0] last_enc;
  logic        cap_back;
  always_comb begin
    last_enc = prev_enc_q[in_wheel];
    cap_back = 1'b0;
    if (last_enc < in_enc) begin
      cap_back = (in_enc - last_enc) > 16'd32767;
    end else if (last_enc > in_enc) begin
      cap_back = !((last_enc - in_enc) > 16'd32767);
    end
  end

  // A tick needs the divider when the stored period is in the usable range.
  logic [15:0] tick_per;
  logic        tick_div;
  assign tick_per = period_q[in_wheel];
  assign tick_div = (tick_per != PERIOD_STOPPED) && (tick_per > 16'(MinPeriod));

  // Serial divider.
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quot;
  assign div_start = in_accept && (in_req == REQ_TICK) && tick_div;

  wspc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (speed_num_q),
    .divisor_i  (tick_per),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Shared MAC: proportional product first, then the integral product.
  logic                     mac_en, mac_load;
  logic [GAIN_W-1:0]        mac_gain;
  logic signed [OPND_W-1:0] mac_opnd;
  logic signed [ACC_W-1:0]  mac_acc;
  assign mac_en   = (state_q == ST_MUL_P) || (state_q == ST_MUL_I);
  assign mac_load = (state_q == ST_MUL_P);
  assign mac_gain = mac_load ? prop_gain_q : integ_gain_q;
  assign mac_opnd = mac_load ? err_q : integ_new_q;

  wspc_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (mac_en),
    .load_i (mac_load),
    .gain_i (mac_gain),
    .opnd_i (mac_opnd),
    .acc_o  (mac_acc)
  );

  // Speed, error and clamped integrator of the current wheel.
  logic [15:0]        cur_mag;
  logic signed [16:0] cur_speed;
  logic signed [17:0] cur_err;
  logic signed [18:0] integ_sum;
  logic signed [17:0] integ_clamp;
  logic [15:0]        target_abs;
  always_comb begin
    cur_mag   = speed_mag_q[wheel_q];
    cur_speed = backward_q[wheel_q] ? -$signed({1'b0, cur_mag}) : $signed({1'b0, cur_mag});
    cur_err   = 18'(target_q) - 18'(cur_speed);
    integ_sum = 19'(integ_q[wheel_q]) + 19'(cur_err);
    if (integ_sum > INTEG_LIMIT) begin
      integ_clamp = 18'(INTEG_LIMIT);
    end else if (integ_sum < -INTEG_LIMIT) begin
      integ_clamp = 18'(-INTEG_LIMIT);
    end else begin
      integ_clamp = integ_sum[17:0];
    end
    target_abs = target_q[15] ? 16'(-target_q) : target_q;
  end

  // Duty saturation and the kill condition.
  logic signed [ACC_W-1:0] duty_lim;
  logic signed [ACC_W-1:0] duty_sat;
  logic                    kill;
  always_comb begin
    duty_lim = $signed({2'b00, max_duty_q, {FRAC_BITS{1'b0}}});
    if (mac_acc > duty_lim) begin
      duty_sat = duty_lim;
    end else if (mac_acc < -duty_lim) begin
      duty_sat = -duty_lim;
    end else begin
      duty_sat = mac_acc;
    end
    kill = estop_q || (countdown_q[wheel_q] == 8'd0);
  end

  // Sign and magnitude of the final duty.
  logic                    fin_rev;
  logic [ACC_W-1:0]        duty_abs;
  logic [15:0]             fin_mag;
  logic                    fin_go;
  assign fin_rev  = duty_q[ACC_W-1];
  assign duty_abs = fin_rev ? ACC_W'(-duty_q) : ACC_W'(duty_q);
  assign fin_mag  = duty_abs[FRAC_BITS+15:FRAC_BITS];
  assign fin_go   = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[5:3])
      REG_PROP_GAIN:    prdata = 64'(prop_gain_q);
      REG_INTEG_GAIN:   prdata = 64'(integ_gain_q);
      REG_SPEED_NUM:    prdata = 64'(speed_num_q);
      REG_MAX_DUTY:     prdata = 64'(max_duty_q);
      REG_MIN_TARGET:   prdata = 64'(min_target_q);
      REG_EN_TIMEOUT:   prdata = 64'(en_timeout_q);
      REG_SAFETY_LEVEL: prdata = 64'(safety_level_q);
      REG_SAFETY_LIMIT: prdata = 64'(safety_limit_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= PROP_GAIN_RST;
      integ_gain_q   <= INTEG_GAIN_RST;
      speed_num_q    <= SPEED_NUM_RST;
      max_duty_q     <= MAX_DUTY_RST;
      min_target_q   <= MIN_TARGET_RST;
      en_timeout_q   <= EN_TIMEOUT_RST;
      safety_level_q <= SAFETY_LEVEL_RST;
      safety_limit_q <= SAFETY_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_PROP_GAIN:    prop_gain_q    <= pwdata[9:0];
        REG_INTEG_GAIN:   integ_gain_q   <= pwdata[9:0];
        REG_SPEED_NUM:    speed_num_q    <= pwdata[39:0];
        REG_MAX_DUTY:     max_duty_q     <= pwdata[15:0];
        REG_MIN_TARGET:   min_target_q   <= pwdata[14:0];
        REG_EN_TIMEOUT:   en_timeout_q   <= pwdata[7:0];
        REG_SAFETY_LEVEL: safety_level_q <= pwdata[15:0];
        REG_SAFETY_LIMIT: safety_limit_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer with wheel state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      safety_q  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        prev_enc_q[i]  <= '0;
        backward_q[i]  <= 1'b0;
        period_q[i]    <= '0;
        speed_mag_q[i] <= '0;
        integ_q[i]     <= '0;
        countdown_q[i] <= EN_TIMEOUT_RST;
        hd_count_q[i]  <= '0;
      end
    end else begin
      // A new result beat takes over the register in the cycle it is loaded.
      if (m_valid_q && m_axis_tready && !fin_go) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_req)
              REQ_CAPTURE: begin
                prev_enc_q[in_wheel] <= in_enc;
                backward_q[in_wheel] <= cap_back ^ in_wheel;
                period_q[in_wheel]   <= in_per;
              end
              REQ_OVERFLOW: begin
                period_q[in_wheel] <= PERIOD_STOPPED;
              end
              REQ_TICK: begin
                if (tick_per == PERIOD_STOPPED) begin
                  speed_mag_q[in_wheel] <= '0;
                end
                state_q <= tick_div ? ST_DIV : ST_CALC;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            speed_mag_q[wheel_q] <= (|div_quot[NUM_W-1:15]) ? SPEED_MAX
                                                             : 16'(div_quot[14:0]);
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (target_abs > {1'b0, min_target_q}) begin
            countdown_q[wheel_q] <= en_timeout_q;
          end else if (countdown_q[wheel_q] != 8'd0) begin
            countdown_q[wheel_q] <= countdown_q[wheel_q] - 8'd1;
          end
          state_q <= ST_MUL_P;
        end
        ST_MUL_P: begin
          state_q <= ST_MUL_I;
        end
        ST_MUL_I: begin
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          integ_q[wheel_q] <= kill ? '0 : integ_new_q;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            m_valid_q <= 1'b1;
            if (fin_mag < safety_level_q) begin
              hd_count_q[wheel_q] <= 9'd1;
              safety_q <= 1'b0;
            end else if (hd_count_q[wheel_q] > {1'b0, safety_limit_q}) begin
              safety_q <= 1'b1;
            end else begin
              hd_count_q[wheel_q] <= hd_count_q[wheel_q] + 9'd1;
              safety_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers of the tick in progress.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      wheel_q  <= in_wheel;
      target_q <= in_target;
      estop_q  <= in_estop;
    end
    if (state_q == ST_CALC) begin
      err_q       <= cur_err;
      integ_new_q <= integ_clamp;
      speed_q     <= cur_speed;
    end
    if (state_q == ST_CLAMP) begin
      duty_q <= kill ? '0 : duty_sat;
    end
    if (fin_go) begin
      out_wheel_q <= wheel_q;
      out_duty_q  <= fin_mag;
      out_rev_q   <= fin_rev;
      out_speed_q <= 16'(speed_q);
    end
  end

  // The flag of the result is the shared safety state after this tick.
  always_comb begin
    out_safety_q = safety_q;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_wheel_q;
  assign m_axis_tdata  = {6'b0, out_speed_q, out_safety_q, out_rev_q, out_duty_q};

endmodule

>>> rtl/wspc_chk.sv
// ----------------------------------------------------------------------------
// wspc_chk
// Port-level checks of the speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
module wspc_chk
  import wspc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        pready
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A control tick occupies the sequencer for the following cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == REQ_TICK)
    |=> !s_axis_tready)
    else $error("input still ready after a control tick");

  // Beats other than control ticks finish in the accept cycle.
  a_event_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != REQ_TICK)
    |=> s_axis_tready)
    else $error("input not ready after a state-only beat");

  // A new result appears as the sequencer returns to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready && pready)
    else $error("result raised while the sequencer is busy");

endmodule

bind wheel_speed_pi_controller wspc_chk u_wspc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

>>> sim/wheel_speed_pi_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_speed_pi_controller_test
// Self-checking bench for the two-wheel speed regulator. A behavioral copy of
// the control law predicts every result beat from the accepted input beats;
// directed cases, a safety-flag sequence and randomized traffic run under
// several register settings, idling and stalling the stream sides at random in some phases.
// ----------------------------------------------------------------------------
module wheel_speed_pi_controller_test;
  import wspc_pkg::*;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int QUIET_CYCLES = 60;
  localparam int STALL_LIMIT  = 3000;
  localparam int INTEG_CLAMP  = 40960;
  localparam int PRINT_LIMIT  = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [1:0]         req;
    logic               whl;
    logic [15:0]        enc;
    logic [15:0]        per;
    logic signed [15:0] tgt;
    logic               estop;
  } wheel_cmd_t;

  typedef struct {
    logic               whl;
    logic [15:0]        duty;
    logic               rev;
    logic               safe;
    logic signed [15:0] spd;
  } drive_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: encoder_count[15:0], capture_period[31:16], target_speed[47:32],
  // emergency_stop[48], zero pad[55:49].
  logic [55:0] s_axis_tdata = '0;
  // tuser: req_type[1:0], wheel[2].
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: drive_duty[15:0], reverse[16], safety_flag[17], measured_speed[33:18].
  logic [39:0] m_axis_tdata;
  // tuser: out_wheel[0].
  logic [0:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  wheel_speed_pi_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Configuration as the predictor sees it.
  logic [9:0]  cfg_prop;
  logic [9:0]  cfg_igain;
  logic [39:0] cfg_num;
  logic [15:0] cfg_max_duty;
  logic [14:0] cfg_min_tgt;
  logic [7:0]  cfg_timeout;
  logic [15:0] cfg_level;
  logic [7:0]  cfg_limit;
  logic [63:0] next_cfg [8];

  // Per-wheel regulator state as the predictor sees it.
  logic [15:0] enc_last [2];
  logic        dir_back [2];
  logic [15:0] per_held [2];
  logic [15:0] speed_held [2];
  int          integ_acc [2];
  logic [7:0]  enable_left [2];
  logic [8:0]  high_run [2];
  logic        safety_on;

  drive_t pending_drive [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_errors = 0;

  // Register field masks, also used to keep random writes in range.
  function automatic logic [63:0] reg_mask(input logic [2:0] idx);
    case (idx) inside
      REG_PROP_GAIN, REG_INTEG_GAIN:   return 64'h3FF;
      REG_SPEED_NUM:                   return 64'hFF_FFFF_FFFF;
      REG_MAX_DUTY, REG_SAFETY_LEVEL:  return 64'hFFFF;
      REG_MIN_TARGET:                  return 64'h7FFF;
      default:                         return 64'hFF;
    endcase
  endfunction

  function automatic logic [63:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_PROP_GAIN:    return 64'(cfg_prop);
      REG_INTEG_GAIN:   return 64'(cfg_igain);
      REG_SPEED_NUM:    return 64'(cfg_num);
      REG_MAX_DUTY:     return 64'(cfg_max_duty);
      REG_MIN_TARGET:   return 64'(cfg_min_tgt);
      REG_EN_TIMEOUT:   return 64'(cfg_timeout);
      REG_SAFETY_LEVEL: return 64'(cfg_level);
      default:          return 64'(cfg_limit);
    endcase
  endfunction

  function automatic void set_register(input logic [2:0] idx, input logic [63:0] val);
    logic [63:0] v;
    v = val & reg_mask(idx);
    case (idx)
      REG_PROP_GAIN:    cfg_prop     = v[9:0];
      REG_INTEG_GAIN:   cfg_igain    = v[9:0];
      REG_SPEED_NUM:    cfg_num      = v[39:0];
      REG_MAX_DUTY:     cfg_max_duty = v[15:0];
      REG_MIN_TARGET:   cfg_min_tgt  = v[14:0];
      REG_EN_TIMEOUT:   cfg_timeout  = v[7:0];
      REG_SAFETY_LEVEL: cfg_level    = v[15:0];
      default:          cfg_limit    = v[7:0];
    endcase
  endfunction

  function automatic void default_settings();
    next_cfg[REG_PROP_GAIN]    = 64'(PROP_GAIN_RST);
    next_cfg[REG_INTEG_GAIN]   = 64'(INTEG_GAIN_RST);
    next_cfg[REG_SPEED_NUM]    = 64'(SPEED_NUM_RST);
    next_cfg[REG_MAX_DUTY]     = 64'(MAX_DUTY_RST);
    next_cfg[REG_MIN_TARGET]   = 64'(MIN_TARGET_RST);
    next_cfg[REG_EN_TIMEOUT]   = 64'(EN_TIMEOUT_RST);
    next_cfg[REG_SAFETY_LEVEL] = 64'(SAFETY_LEVEL_RST);
    next_cfg[REG_SAFETY_LIMIT] = 64'(SAFETY_LIMIT_RST);
  endfunction

  // Predictor state after reset.
  function automatic void reset_regulator();
    default_settings();
    for (int i = 0; i < 8; i++) set_register(3'(i), next_cfg[i]);
    for (int w = 0; w < 2; w++) begin
      enc_last[w]    = '0;
      dir_back[w]    = 1'b0;
      per_held[w]    = '0;
      speed_held[w]  = '0;
      integ_acc[w]   = 0;
      enable_left[w] = EN_TIMEOUT_RST;
      high_run[w]    = '0;
    end
    safety_on = 1'b0;
  endfunction

  // Applies one accepted beat to the predicted state; a control tick queues
  // the drive result it must produce.
  function automatic void regulate(input wheel_cmd_t c);
    int w;
    logic back;
    longint target, speed, err, acc, duty, lim, mag;
    longint unsigned quo;
    drive_t r;
    w = int'(c.whl);
    if (c.req == REQ_CAPTURE) begin
      // Direction from the encoder movement, wrapping at half range.
      back = 1'b0;
      if (enc_last[w] < c.enc) back = (int'(c.enc) - int'(enc_last[w])) > 32767;
      else if (enc_last[w] > c.enc) back = !((int'(enc_last[w]) - int'(c.enc)) > 32767);
      enc_last[w] = c.enc;
      dir_back[w] = (w == 1) ? !back : back;
      per_held[w] = c.per;
    end else if (c.req == REQ_OVERFLOW) begin
      per_held[w] = PERIOD_STOPPED;
    end else if (c.req == REQ_TICK) begin
      target = longint'(c.tgt);
      // Speed magnitude; a short period keeps the previous value.
      if (per_held[w] == PERIOD_STOPPED) begin
        speed_held[w] = '0;
      end else if (per_held[w] > MIN_PERIOD_DEFAULT) begin
        quo = longint'(cfg_num) / longint'(per_held[w]);
        speed_held[w] = (quo > SPEED_MAX) ? SPEED_MAX : quo[15:0];
      end
      speed = dir_back[w] ? -longint'(speed_held[w]) : longint'(speed_held[w]);

      // Enable countdown.
      if ((target < 0 ? -target : target) > longint'(cfg_min_tgt)) begin
        enable_left[w] = cfg_timeout;
      end else if (enable_left[w] != 0) begin
        enable_left[w] = enable_left[w] - 8'd1;
      end

      // PI step with a clamped integrator, then duty saturation.
      err = target - speed;
      acc = longint'(integ_acc[w]) + err;
      if (acc > INTEG_CLAMP) acc = INTEG_CLAMP;
      if (acc < -INTEG_CLAMP) acc = -INTEG_CLAMP;
      integ_acc[w] = int'(acc);
      duty = longint'(cfg_prop) * err + longint'(cfg_igain) * acc;
      lim = longint'(cfg_max_duty) << FRAC_BITS;
      if (duty > lim) duty = lim;
      if (duty < -lim) duty = -lim;
      if (c.estop || enable_left[w] == 0) begin
        integ_acc[w] = 0;
        duty = 0;
      end
      r.rev = duty < 0;
      mag = (r.rev ? -duty : duty) >> FRAC_BITS;

      // High-duty safety counter.
      if (mag < longint'(cfg_level)) begin
        high_run[w] = 9'd1;
        safety_on = 1'b0;
      end else if (high_run[w] > cfg_limit) begin
        safety_on = 1'b1;
      end else begin
        high_run[w] = high_run[w] + 9'd1;
        safety_on = 1'b0;
      end
      r.whl  = c.whl;
      r.duty = mag[15:0];
      r.safe = safety_on;
      r.spd  = speed[15:0];
      pending_drive.push_back(r);
    end
  endfunction

  function automatic wheel_cmd_t mk_cmd(input logic [1:0] req, input logic whl,
                                        input logic [15:0] enc, input logic [15:0] per,
                                        input logic signed [15:0] tgt, input logic estop);
    wheel_cmd_t c;
    c.req = req;
    c.whl = whl;
    c.enc = enc;
    c.per = per;
    c.tgt = tgt;
    c.estop = estop;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= PRINT_LIMIT)
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin src_idle_pct = 49; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 49; end
      IDLE_BOTH:     begin src_idle_pct = 27; sink_stall_pct = 27; end
      default:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  // Sends one input beat, with random idle cycles ahead of it.
  task automatic send_beat(input wheel_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, c.estop, c.tgt, c.per, c.enc};
    s_axis_tuser  <= {c.whl, c.req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    regulate(c);
    n_sent++;
    if (c.req == REQ_TICK) n_ticks++;
  endtask

  // Holds the input side idle until every predicted result has arrived.
  task automatic wait_for_results(input bit settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_drive.size() != 0) @(posedge clk_i);
    if (settle) repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_register(idx, val);
    n_writes++;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== reg_value(idx))
      report_mismatch($sformatf("readback of register %0d", idx), prdata, reg_value(idx));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings();
    wait_for_results(1'b1);
    for (int i = 0; i < 8; i++) write_reg(3'(i), next_cfg[i] & reg_mask(3'(i)));
  endtask

  // Phase settings: defaults, all fields at maximum, all zero, then random.
  function automatic void pick_settings(input int ph);
    case (ph)
      0: default_settings();
      1: for (int i = 0; i < 8; i++) next_cfg[i] = reg_mask(3'(i));
      2: for (int i = 0; i < 8; i++) next_cfg[i] = '0;
      default: begin
        next_cfg[REG_PROP_GAIN]    = 64'($urandom_range(1023));
        next_cfg[REG_INTEG_GAIN]   = 64'($urandom_range(1023));
        next_cfg[REG_SPEED_NUM]    = 64'($urandom_range(32767)) *
                                     64'($urandom_range(30000, 1000));
        next_cfg[REG_MAX_DUTY]     = 64'($urandom_range(1) ? $urandom_range(65535)
                                                           : $urandom_range(2000));
        next_cfg[REG_MIN_TARGET]   = 64'($urandom_range(200));
        next_cfg[REG_EN_TIMEOUT]   = 64'($urandom_range(8, 1));
        next_cfg[REG_SAFETY_LEVEL] = 64'($urandom_range(32'(next_cfg[REG_MAX_DUTY])));
        next_cfg[REG_SAFETY_LIMIT] = 64'($urandom_range(10));
      end
    endcase
  endfunction

  // Plausible encoder movement, with wrap-boundary jumps and random leaps.
  function automatic logic [15:0] next_encoder(input logic whl);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return enc_last[whl] + 16'($urandom_range(32769, 32767));
      2:       return enc_last[whl];
      default: return enc_last[whl] + 16'($urandom_range(600)) - 16'd300;
    endcase
  endfunction

  function automatic logic [15:0] next_period();
    case ($urandom_range(19))
      0:       return 16'($urandom_range(MIN_PERIOD_DEFAULT));
      1:       return PERIOD_STOPPED;
      2:       return $urandom_range(1) ? 16'(MIN_PERIOD_DEFAULT + 1) : 16'hFFFE;
      default: return 16'($urandom_range(65534, MIN_PERIOD_DEFAULT + 1));
    endcase
  endfunction

  // Targets: small ones to run out the enable window, values around the
  // enable threshold, the extremes, and anything at all.
  function automatic logic signed [15:0] next_target();
    int t;
    case ($urandom_range(9))
      0, 1: t = int'($urandom_range(40)) - 20;
      2: begin
        t = int'(cfg_min_tgt) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) t = -t;
      end
      3:       t = $urandom_range(1) ? 32767 : -32768;
      default: t = int'($urandom);
    endcase
    return 16'(t);
  endfunction

  // Mostly well-formed capture/tick traffic, with some noise beats.
  task automatic random_beat();
    wheel_cmd_t c;
    int pick;
    pick    = $urandom_range(99);
    c.whl   = 1'($urandom_range(1));
    c.enc   = 16'($urandom);
    c.per   = 16'($urandom);
    c.tgt   = 16'($urandom);
    c.estop = ($urandom_range(19) == 0);
    if (pick < 5) begin
      c.req = 2'($urandom_range(3));
    end else if (pick < 40) begin
      c.req = REQ_CAPTURE;
      c.enc = next_encoder(c.whl);
      c.per = next_period();
    end else if (pick < 45) begin
      c.req = REQ_OVERFLOW;
    end else if (pick < 48) begin
      c.req = REQ_UNUSED;
    end else begin
      c.req = REQ_TICK;
      c.tgt = next_target();
    end
    send_beat(c);
  endtask

  // Reset values, then write and read back every register.
  task automatic test_registers();
    for (int i = 0; i < 8; i++) read_reg(3'(i));
    for (int i = 0; i < 8; i++) begin
      write_reg(3'(i), {$urandom, $urandom} & reg_mask(3'(i)));
      read_reg(3'(i));
    end
    default_settings();
    apply_settings();
  endtask

  task automatic test_directed();
    set_idle(IDLE_NONE);
    // Default gains, zero numerator: speeds stay at zero.
    send_beat(mk_cmd(REQ_UNUSED, 1'b0, 16'hFFFF, 16'hFFFF, -16'sd1, 1'b1));
    // A tiny negative duty truncates to zero with reverse set.
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, -16'sd1, 1'b0));
    // No encoder movement and a zero period.
    send_beat(mk_cmd(REQ_CAPTURE, 1'b0, 16'h0000, 16'h0000, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sh7FFF, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, 16'sh8000, 1'b1));
    send_beat(mk_cmd(REQ_CAPTURE, 1'b1, 16'hFFFF, 16'hFFFE, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_OVERFLOW, 1'b1, 16'h1234, 16'h4321, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, 16'sh7FFF, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, 16'sh8000, 1'b0));

    // Largest numerator saturates the speed; a one-tick enable window.
    wait_for_results(1'b1);
    write_reg(REG_SPEED_NUM, 64'hFF_FFFF_FFFF);
    write_reg(REG_EN_TIMEOUT, 64'd1);
    send_beat(mk_cmd(REQ_CAPTURE, 1'b0, 16'h8000, 16'd201, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sd0, 1'b0));
    // Period at the minimum keeps the previous magnitude.
    send_beat(mk_cmd(REQ_CAPTURE, 1'b0, 16'h7FFF, 16'd200, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sd100, 1'b0));
    // Small targets run the enable window out.
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sd5, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, -16'sd5, 1'b0));
    // A captured stopped period, then an equal count on the inverted wheel.
    send_beat(mk_cmd(REQ_CAPTURE, 1'b1, 16'h7FFF, 16'hFFFF, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, 16'sd2000, 1'b0));
    send_beat(mk_cmd(REQ_CAPTURE, 1'b1, 16'h7FFF, 16'hFFFE, 16'sd0, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, -16'sd2000, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, 16'sd0, 1'b1));
  endtask

  // High duty held past a short tick limit, cleared by a low-duty tick.
  task automatic test_safety();
    next_cfg[REG_PROP_GAIN]    = 64'd1023;
    next_cfg[REG_INTEG_GAIN]   = 64'd0;
    next_cfg[REG_SPEED_NUM]    = 64'd0;
    next_cfg[REG_MAX_DUTY]     = 64'd65535;
    next_cfg[REG_MIN_TARGET]   = 64'd0;
    next_cfg[REG_EN_TIMEOUT]   = 64'd255;
    next_cfg[REG_SAFETY_LEVEL] = 64'd1000;
    next_cfg[REG_SAFETY_LIMIT] = 64'd2;
    apply_settings();
    set_idle(IDLE_BOTH);
    repeat (6) send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sh7FFF, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b1, 16'h0000, 16'h0000, 16'sd0, 1'b0));
    repeat (3) send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sh7FFF, 1'b0));
    send_beat(mk_cmd(REQ_TICK, 1'b0, 16'h0000, 16'h0000, 16'sd0, 1'b0));
  endtask

  // Random traffic over eight settings, cycling through the idle modes.
  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      pick_settings(ph);
      apply_settings();
      set_idle(idle_mode_e'(ph % 4));
      for (int k = 0; k < 125; k++) begin
        if (k == 60 || $urandom_range(199) == 0) wait_for_results(1'b0);
        random_beat();
      end
    end
  endtask

  // Receiver side: random stalls per the current idle mode.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result beat with the oldest predicted drive.
  always @(posedge clk_i) begin : check_results
    drive_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_drive.size() == 0) begin
        report_mismatch("result beat with nothing pending, wheel", m_axis_tuser[0], -1);
      end else begin
        want = pending_drive.pop_front();
        if (m_axis_tuser[0] !== want.whl)
          report_mismatch("out_wheel", m_axis_tuser[0], want.whl);
        if (m_axis_tdata[15:0] !== want.duty)
          report_mismatch("drive_duty", m_axis_tdata[15:0], want.duty);
        if (m_axis_tdata[16] !== want.rev)
          report_mismatch("reverse", m_axis_tdata[16], want.rev);
        if (m_axis_tdata[17] !== want.safe)
          report_mismatch("safety_flag", m_axis_tdata[17], want.safe);
        if (m_axis_tdata[33:18] !== want.spd)
          report_mismatch("measured_speed", $signed(m_axis_tdata[33:18]), want.spd);
      end
    end
  end

  // Watchdog: too long with no beat on any port ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_regulator();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_registers();
    test_directed();
    test_safety();
    test_random();
    set_idle(IDLE_NONE);
    wait_for_results(1'b1);
    $display("Sent %0d input beats (%0d control ticks), checked %0d result beats.",
             n_sent, n_ticks, n_results);
    $display("Used %0d register writes over default, all-max, all-zero and random settings.",
             n_writes);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
